[hdl/rqf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqf_pkg
// shared types, codes and sizes for the replication quorum filter
// ----------------------------------------------------------------------------
package rqf_pkg;

    // slot table and replica group sizes
    localparam int SLOTS        = 64;
    localparam int MAX_REPLICAS = 8;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(MAX_REPLICAS + 1);
    localparam int CMP_W        = 6;

    // field widths
    localparam int CMD_W  = 2;
    localparam int VIEW_W = 31;
    localparam int SEQ_W  = 32;
    localparam int REP_W  = 5;
    localparam int VERD_W = 2;
    localparam int QS_W   = 4;

    // configuration bus
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OUT_PREP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IN_PREP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREP_OK  = 2'd2;

    // verdict codes
    localparam logic [VERD_W-1:0] VERDICT_PASS    = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_DROP    = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_DELIVER = 2'd2;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_NORMAL_MODE    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_CURRENT_VIEW   = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_QUORUM_MEMBERS = 4'h8;

    // register reset values
    localparam logic              RST_NORMAL_MODE    = 1'b1;
    localparam logic [VIEW_W-1:0] RST_CURRENT_VIEW   = '0;
    localparam logic [QS_W-1:0]   RST_QUORUM_MEMBERS = 4'd2;

    typedef struct packed {
        logic [VIEW_W-1:0]       view;
        logic [SEQ_W-1:0]        seq;
        logic [MAX_REPLICAS-1:0] votes;
        logic                    done;
    } slot_entry_t;

    // a slot that was never written reads as free to arm
    localparam slot_entry_t SLOT_RESET = '{view: '0, seq: '0, votes: '0, done: 1'b1};

endpackage

[hdl/rqf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqf_req_if
// request channel carrying one protocol message per beat
// ----------------------------------------------------------------------------
interface rqf_req_if;
    import rqf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [VIEW_W-1:0] view;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  batch_start;
    logic [REP_W-1:0]  replica_index;

    modport source (
        output valid, cmd, view, seq, batch_start, replica_index,
        input  ready
    );

    modport sink (
        input  valid, cmd, view, seq, batch_start, replica_index,
        output ready
    );

endinterface

[hdl/rqf_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqf_rsp_if
// response channel carrying one filter verdict per beat
// ----------------------------------------------------------------------------
interface rqf_rsp_if;
    import rqf_pkg::*;

    logic              valid;
    logic              ready;
    logic [VERD_W-1:0] verdict;
    logic              quorum_now;
    logic [SEQ_W-1:0]  last_op_out;

    modport source (
        output valid, verdict, quorum_now, last_op_out,
        input  ready
    );

    modport sink (
        input  valid, verdict, quorum_now, last_op_out,
        output ready
    );

endinterface

[hdl/replication_quorum_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replication_quorum_filter
// fast-path prepare / prepare-ok filter around a slot table in block memory
// ----------------------------------------------------------------------------
// usage
//   req : one message per beat (cmd, view, seq, batch_start, replica_index)
//   rsp : one verdict per message (verdict, quorum_now, last_op_out)
//   apb : normal_mode at 0x0, current_view at 0x4, quorum_members at 0x8;
//         pready is tied high, reads return the register value
// sequencing
//   a message is taken only in the idle state; its slot is read into a
//   register on accept, and it is resolved and written back once the
//   response register is free, which then registers its verdict; the
//   next message is not taken before the last one has been resolved
// reset
//   last_op and the registers return to their reset values; the slot valid
//   bits are cleared, so every slot reads as free to arm straight away
// back-pressure
//   while rsp stalls, one further message is taken and held after its read
//   until the response register frees; req then stays low
// ----------------------------------------------------------------------------
module replication_quorum_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    rqf_req_if.sink                    req,
    rqf_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqf_pkg::PADDR_W-1:0] paddr,
    input  logic [rqf_pkg::PDATA_W-1:0] pwdata,
    output logic [rqf_pkg::PDATA_W-1:0] prdata,
    output logic                       pready
);
    import rqf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // configuration registers
    logic              normal_mode_reg;
    logic [VIEW_W-1:0] current_view_reg;
    logic [QS_W-1:0]   quorum_members_reg;
    logic              cfg_write;

    // control
    logic state_reg, state_next;
    logic req_fire;
    logic exec_fire;

    // message held across the read
    logic [CMD_W-1:0]  cmd_reg;
    logic [VIEW_W-1:0] view_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [SEQ_W-1:0]  batch_reg;
    logic [REP_W-1:0]  rep_reg;

    // slot memory
    slot_entry_t       slot_mem [SLOTS];
    logic [SLOTS-1:0]  slot_valid_reg;
    slot_entry_t       rd_entry_reg;
    logic              rd_valid_reg;
    slot_entry_t       cur_entry;
    slot_entry_t       wr_entry;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;

    // resolve
    logic [SEQ_W-1:0]        last_op_reg, last_op_next;
    logic [VERD_W-1:0]       verdict;
    logic                    qnow;
    logic                    slot_match;
    logic [MAX_REPLICAS-1:0] votes_upd;
    logic [CMP_W-1:0]        vote_count;
    logic [CMP_W-1:0]        vote_target;

    // response register
    logic              out_valid_reg, out_valid_next;
    logic [VERD_W-1:0] out_verdict_reg;
    logic              out_qnow_reg;
    logic [SEQ_W-1:0]  out_last_op_reg;

    function automatic logic [CNT_W-1:0] popcount(input logic [MAX_REPLICAS-1:0] v);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MAX_REPLICAS; i++)
        begin
            cnt = cnt + CNT_W'(v[i]);
        end
        return cnt;
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_mode_reg    <= RST_NORMAL_MODE;
            current_view_reg   <= RST_CURRENT_VIEW;
            quorum_members_reg <= RST_QUORUM_MEMBERS;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                ADDR_NORMAL_MODE:    normal_mode_reg    <= pwdata[0];
                ADDR_CURRENT_VIEW:   current_view_reg   <= pwdata[VIEW_W-1:0];
                ADDR_QUORUM_MEMBERS: quorum_members_reg <= pwdata[QS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_NORMAL_MODE:    prdata = {{(PDATA_W-1){1'b0}}, normal_mode_reg};
            ADDR_CURRENT_VIEW:   prdata = {{(PDATA_W-VIEW_W){1'b0}}, current_view_reg};
            ADDR_QUORUM_MEMBERS: prdata = {{(PDATA_W-QS_W){1'b0}}, quorum_members_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencing: take a message, read its slot, then resolve once the
    // response register is free
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_fire) state_next = S_EXEC;
            S_EXEC: if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg   <= req.cmd;
            view_reg  <= req.view;
            seq_reg   <= req.seq;
            batch_reg <= req.batch_start;
            rep_reg   <= req.replica_index;
        end
    end

    // ------------------------------------------------------------------
    // slot memory: read on accept, write back on resolve; the write of one
    // message always lands before the read of the next, so no forwarding
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_entry;
        end
        if (req_fire)
        begin
            rd_entry_reg <= slot_mem[req.seq[SLOT_W-1:0]];
        end
    end

    // per-slot valid bits stand in for a clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_valid_reg[wr_addr] <= 1'b1;
            end
            if (req_fire)
            begin
                rd_valid_reg <= slot_valid_reg[req.seq[SLOT_W-1:0]];
            end
        end
    end

    assign cur_entry = rd_valid_reg ? rd_entry_reg : SLOT_RESET;
    assign wr_addr   = seq_reg[SLOT_W-1:0];

    // ------------------------------------------------------------------
    // resolve
    // ------------------------------------------------------------------
    assign slot_match = (cur_entry.view == view_reg) && (cur_entry.seq == seq_reg);

    // out-of-range replica indexes set no bit
    always_comb
    begin
        for (int i = 0; i < MAX_REPLICAS; i++)
        begin
            votes_upd[i] = cur_entry.votes[i] || (rep_reg == REP_W'(i));
        end
    end

    assign vote_count  = CMP_W'(popcount(votes_upd));
    assign vote_target = CMP_W'(quorum_members_reg) - CMP_W'(1);

    always_comb
    begin
        verdict      = VERDICT_PASS;
        qnow         = 1'b0;
        last_op_next = last_op_reg;
        wr_en        = 1'b0;
        wr_entry     = cur_entry;
        case (cmd_reg)
            CMD_OUT_PREP:
            begin
                // re-arm a done slot for a new view or sequence
                if (cur_entry.done && !slot_match)
                begin
                    wr_en          = exec_fire;
                    wr_entry.view  = view_reg;
                    wr_entry.seq   = seq_reg;
                    wr_entry.votes = '0;
                end
            end
            CMD_IN_PREP:
            begin
                if (!normal_mode_reg)
                begin
                    verdict = VERDICT_PASS;
                end
                else if ((view_reg < current_view_reg) || (seq_reg <= last_op_reg))
                begin
                    verdict = VERDICT_DROP;
                end
                else if (view_reg > current_view_reg)
                begin
                    verdict = VERDICT_PASS;
                end
                else if ({1'b0, batch_reg} > ({1'b0, last_op_reg} + (SEQ_W+1)'(1)))
                begin
                    // batch gap
                    verdict = VERDICT_PASS;
                end
                else
                begin
                    verdict      = VERDICT_DELIVER;
                    last_op_next = seq_reg;
                end
            end
            CMD_PREP_OK:
            begin
                if (slot_match)
                begin
                    wr_en          = exec_fire;
                    wr_entry.votes = votes_upd;
                    if ((quorum_members_reg != '0) && (vote_count == vote_target))
                    begin
                        wr_entry.done = 1'b1;
                        qnow          = 1'b1;
                        verdict       = VERDICT_PASS;
                        if (last_op_reg < seq_reg)
                        begin
                            last_op_next = seq_reg;
                        end
                    end
                    else
                    begin
                        verdict = VERDICT_DROP;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_op_reg <= '0;
        end
        else if (exec_fire)
        begin
            last_op_reg <= last_op_next;
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_verdict_reg <= verdict;
            out_qnow_reg    <= qnow;
            out_last_op_reg <= last_op_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.verdict     = out_verdict_reg;
    assign rsp.quorum_now  = out_qnow_reg;
    assign rsp.last_op_out = out_last_op_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_EXEC))
        else $error("response raised without a resolve cycle");

    a_qnow_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.quorum_now) |-> (rsp.verdict == VERDICT_PASS))
        else $error("completing vote not passed");

    a_last_op_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (last_op_reg >= $past(last_op_reg)))
        else $error("last_op went backwards");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EXEC) && !req_fire)
        else $error("slot write outside resolve cycle");

endmodule

[dv/rqf_verdict_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqf_verdict_check
// watches the message, verdict and register channels of the quorum filter,
// predicts every verdict from its own slot table and compares beat by beat
// ----------------------------------------------------------------------------
module rqf_verdict_check (
    input  logic                        clk,
    input  logic                        rst_n,
    rqf_req_if                          req,
    rqf_rsp_if                          rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [rqf_pkg::PADDR_W-1:0] paddr,
    input  logic [rqf_pkg::PDATA_W-1:0] pwdata,
    output int                          errors,
    output int                          pending,
    output int                          n_results,
    output int                          n_deliver,
    output int                          n_drop,
    output int                          n_quorum
);
    import rqf_pkg::*;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic              quorum_now;
        logic [SEQ_W-1:0]  last_op;
    } verdict_beat_t;

    localparam logic [MAX_REPLICAS-1:0] ONE_VOTE = MAX_REPLICAS'(1);

    // predicted slot table and registers
    logic [VIEW_W-1:0]       tbl_view  [SLOTS];
    logic [SEQ_W-1:0]        tbl_seq   [SLOTS];
    logic [MAX_REPLICAS-1:0] tbl_votes [SLOTS];
    logic                    tbl_done  [SLOTS];
    logic [SEQ_W-1:0]        m_last_op;
    logic                    m_normal;
    logic [VIEW_W-1:0]       m_view;
    logic [QS_W-1:0]         m_quorum;

    verdict_beat_t awaited_q[$];

    function automatic verdict_beat_t filter_message(
        input logic [CMD_W-1:0]  cmd,
        input logic [VIEW_W-1:0] view,
        input logic [SEQ_W-1:0]  seq,
        input logic [SEQ_W-1:0]  batch,
        input logic [REP_W-1:0]  rep
    );
        verdict_beat_t        r;
        logic [SLOT_W-1:0]    idx;
        idx          = seq[SLOT_W-1:0];
        r.verdict    = VERDICT_PASS;
        r.quorum_now = 1'b0;
        case (cmd)
            CMD_OUT_PREP:
            begin
                if (tbl_done[idx] && (tbl_view[idx] != view || tbl_seq[idx] != seq))
                begin
                    tbl_view[idx]  = view;
                    tbl_seq[idx]   = seq;
                    tbl_votes[idx] = '0;
                end
            end
            CMD_IN_PREP:
            begin
                if (!m_normal)
                    r.verdict = VERDICT_PASS;
                else if (view < m_view || seq <= m_last_op)
                    r.verdict = VERDICT_DROP;
                else if (view > m_view)
                    r.verdict = VERDICT_PASS;
                else if ({1'b0, batch} > {1'b0, m_last_op} + 33'd1)
                    r.verdict = VERDICT_PASS;
                else
                begin
                    m_last_op = seq;
                    r.verdict = VERDICT_DELIVER;
                end
            end
            CMD_PREP_OK:
            begin
                if (tbl_view[idx] == view && tbl_seq[idx] == seq)
                begin
                    if (rep < MAX_REPLICAS)
                        tbl_votes[idx] = tbl_votes[idx] | (ONE_VOTE << rep);
                    if (m_quorum != '0 && $countones(tbl_votes[idx]) == int'(m_quorum) - 1)
                    begin
                        tbl_done[idx] = 1'b1;
                        if (m_last_op < seq)
                            m_last_op = seq;
                        r.quorum_now = 1'b1;
                    end
                    else
                        r.verdict = VERDICT_DROP;
                end
            end
            default: ;
        endcase
        r.last_op = m_last_op;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_view[i]  = '0;
                tbl_seq[i]   = '0;
                tbl_votes[i] = '0;
                tbl_done[i]  = 1'b1;
            end
            m_last_op = '0;
            m_normal  = RST_NORMAL_MODE;
            m_view    = RST_CURRENT_VIEW;
            m_quorum  = RST_QUORUM_MEMBERS;
            awaited_q.delete();
            errors    = 0;
            pending   = 0;
            n_results = 0;
            n_deliver = 0;
            n_drop    = 0;
            n_quorum  = 0;
        end
        else
        begin
            // verdict first: it always belongs to an older message
            if (rsp.valid && rsp.ready)
            begin
                n_results++;
                if (awaited_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: verdict beat with nothing awaited (verdict %0d)",
                             $time, rsp.verdict);
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (rsp.verdict !== want.verdict)
                    begin
                        errors++;
                        $display("%0t: verdict expected %0d got %0d",
                                 $time, want.verdict, rsp.verdict);
                    end
                    if (rsp.quorum_now !== want.quorum_now)
                    begin
                        errors++;
                        $display("%0t: quorum_now expected %0d got %0d",
                                 $time, want.quorum_now, rsp.quorum_now);
                    end
                    if (rsp.last_op_out !== want.last_op)
                    begin
                        errors++;
                        $display("%0t: last_op_out expected %0h got %0h",
                                 $time, want.last_op, rsp.last_op_out);
                    end
                    if (want.verdict == VERDICT_DELIVER)
                        n_deliver++;
                    if (want.verdict == VERDICT_DROP)
                        n_drop++;
                    if (want.quorum_now)
                        n_quorum++;
                end
            end
            if (req.valid && req.ready)
                awaited_q.push_back(filter_message(req.cmd, req.view, req.seq,
                                                   req.batch_start, req.replica_index));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_NORMAL_MODE:    m_normal = pwdata[0];
                    ADDR_CURRENT_VIEW:   m_view   = pwdata[VIEW_W-1:0];
                    ADDR_QUORUM_MEMBERS: m_quorum = pwdata[QS_W-1:0];
                    default: ;
                endcase
            end
            pending = awaited_q.size();
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the quorum filter with leader and follower message flows, random
// noise and register changes; a separate watcher predicts and checks verdicts
// ----------------------------------------------------------------------------
module tb;
    import rqf_pkg::*;

    // the fourth command code has no meaning and must pass untouched
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CMD_W-1:0] ALL_CMDS [4] = '{CMD_OUT_PREP, CMD_IN_PREP,
                                                  CMD_PREP_OK, CMD_UNUSED};
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rqf_req_if req_if ();
    rqf_rsp_if rsp_if ();

    int errors;
    int pending;
    int n_results;
    int n_deliver;
    int n_drop;
    int n_quorum;
    int n_sent;
    int rsp_gap_left;
    int idle_cycles;

    // hold_reqs / hold_seen: one long receiver stall per request;
    // no_gaps: both sides run flat out
    int hold_reqs;
    int hold_seen;
    bit no_gaps;

    // highest sequence handed out so far and the view in force
    logic [SEQ_W-1:0]  op_head;
    logic [VIEW_W-1:0] cur_view;

    replication_quorum_filter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rqf_verdict_check verdict_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending),
        .n_results (n_results),
        .n_deliver (n_deliver),
        .n_drop    (n_drop),
        .n_quorum  (n_quorum)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // verdict side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        rsp_if.ready = 1'b0;
        rsp_gap_left = 0;
        hold_seen    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_reqs)
            begin
                hold_seen    = hold_reqs;
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (no_gaps)
                rsp_if.ready = 1'b1;
            else if (rsp_gap_left > 0)
            begin
                rsp_if.ready = 1'b0;
                rsp_gap_left--;
            end
            else
            begin
                rsp_if.ready = 1'b1;
                if ($urandom_range(0, 5) == 0)
                    rsp_gap_left = pick_gap();
            end
        end
    end

    // watchdog: ends the run once nothing has been accepted for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: watchdog, no beat for %0d cycles, %0d verdicts awaited",
                 WATCHDOG_LIMIT, pending);
        $display("tb: done, errors");
        $finish;
    end

    // one message beat; valid stays up when the next beat follows at once
    task automatic send_msg(
        input logic [CMD_W-1:0]  cmd,
        input logic [VIEW_W-1:0] view,
        input logic [SEQ_W-1:0]  seq,
        input logic [SEQ_W-1:0]  batch,
        input logic [REP_W-1:0]  rep
    );
        int gap;
        req_if.valid         = 1'b1;
        req_if.cmd           = cmd;
        req_if.view          = view;
        req_if.seq           = seq;
        req_if.batch_start   = batch;
        req_if.replica_index = rep;
        do
            @(posedge clk);
        while (!req_if.ready);
        n_sent++;
        @(negedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // sender stops until every verdict is back, plus a short settling pause
    task automatic drain();
        req_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // registers only change with the filter idle
    task automatic set_config(input logic normal, input logic [VIEW_W-1:0] view,
                              input logic [QS_W-1:0] quorum);
        drain();
        write_reg(ADDR_NORMAL_MODE, PDATA_W'(normal));
        write_reg(ADDR_CURRENT_VIEW, PDATA_W'(view));
        write_reg(ADDR_QUORUM_MEMBERS, PDATA_W'(quorum));
        cur_view = view;
    endtask

    // leader side: arm a slot, then collect votes, some broken or repeated
    task automatic leader_round();
        int                kind;
        int                n_votes;
        logic [SEQ_W-1:0]  s;
        logic [VIEW_W-1:0] vview;
        logic [SEQ_W-1:0]  vseq;
        logic [REP_W-1:0]  rep;
        op_head += $urandom_range(1, 3);
        s = op_head;
        send_msg(CMD_OUT_PREP, cur_view, s, $urandom, REP_W'($urandom_range(0, 31)));
        n_votes = $urandom_range(1, 10);
        for (int i = 0; i < n_votes; i++)
        begin
            vview = cur_view;
            vseq  = s;
            rep   = ($urandom_range(0, 7) == 0) ? REP_W'($urandom_range(8, 31))
                                                : REP_W'($urandom_range(0, 7));
            kind  = $urandom_range(0, 15);
            if (kind == 0)
                vview = cur_view ^ VIEW_W'(1);
            else if (kind == 1)
                vseq = s + SLOTS;   // same slot, other operation
            else if (kind == 2)
                send_msg(CMD_OUT_PREP, cur_view, s, $urandom, rep);  // no re-arm
            send_msg(CMD_PREP_OK, vview, vseq, $urandom, rep);
        end
    endtask

    // follower side: incoming prepares, mostly in order, some stale or gapped
    task automatic follower_round();
        int                kind;
        logic [VIEW_W-1:0] view;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  batch;
        op_head += $urandom_range(1, 3);
        kind = $urandom_range(0, 15);
        view = (kind == 0) ? cur_view + VIEW_W'(1) :
               (kind == 1) ? cur_view - VIEW_W'(1) : cur_view;
        seq  = ($urandom_range(0, 9) == 0) ? op_head - $urandom_range(1, 5) : op_head;
        case ($urandom_range(0, 3))
            0:       batch = $urandom_range(0, 3);
            3:       batch = op_head + $urandom_range(0, 10);
            default: batch = op_head - $urandom_range(1, 6);
        endcase
        send_msg(CMD_IN_PREP, view, seq, batch, REP_W'($urandom_range(0, 31)));
    endtask

    task automatic noise_item();
        send_msg(ALL_CMDS[$urandom_range(0, 3)], VIEW_W'($urandom), $urandom, $urandom,
                 REP_W'($urandom_range(0, 31)));
    endtask

    // one register setting worth of random traffic
    task automatic run_phase(input int target, input bit pressure, input bit quiet);
        int  first;
        int  kind;
        bit  paused;
        first  = n_sent;
        paused = 1'b0;
        if (pressure)
        begin
            // receiver holds off while the sender keeps pushing back-to-back
            hold_reqs++;
            no_gaps  = 1'b1;
            repeat (12) follower_round();
            no_gaps  = 1'b0;
        end
        if (quiet)
            no_gaps = 1'b1;
        while (n_sent - first < target)
        begin
            if (quiet && n_sent - first >= target / 3)
                no_gaps = 1'b0;
            if (!paused && n_sent - first >= target / 2)
            begin
                drain();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45)
                leader_round();
            else if (kind < 80)
                repeat ($urandom_range(1, 3)) follower_round();
            else
                repeat ($urandom_range(1, 3)) noise_item();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        logic [VIEW_W-1:0] mid_view;
        logic [VIEW_W-1:0] late_view;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_if.valid         = 1'b0;
        req_if.cmd           = CMD_OUT_PREP;
        req_if.view          = '0;
        req_if.seq           = '0;
        req_if.batch_start   = '0;
        req_if.replica_index = '0;
        hold_reqs            = 0;
        no_gaps              = 1'b0;
        n_sent               = 0;
        op_head              = '0;
        cur_view             = RST_CURRENT_VIEW;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset registers: normal status, view 0, quorum of 2
        // a never-armed slot already matches view 0 / seq 0 and takes a vote
        send_msg(CMD_PREP_OK, '0, 32'd0, '0, 5'd0);
        send_msg(CMD_OUT_PREP, '0, 32'd0, '0, 5'd0);        // same view and seq, kept
        send_msg(CMD_OUT_PREP, 31'd5, 32'd64, '0, 5'd0);    // re-arm slot 0
        send_msg(CMD_PREP_OK, 31'd5, 32'd64, '0, 5'd9);     // replica out of range
        send_msg(CMD_PREP_OK, 31'd5, 32'd64, '0, 5'd3);     // completes the quorum
        send_msg(CMD_PREP_OK, 31'd5, 32'd64, '0, 5'd4);     // one vote too many
        send_msg(CMD_PREP_OK, 31'd4, 32'd64, '0, 5'd1);     // slot mismatch
        send_msg(CMD_IN_PREP, '0, 32'd64, '0, 5'd0);        // stale sequence
        send_msg(CMD_IN_PREP, '0, 32'd65, 32'd65, 5'd0);    // in order, delivered
        send_msg(CMD_IN_PREP, '0, 32'd70, 32'd67, 5'd0);    // batch gap
        send_msg(CMD_IN_PREP, 31'h7FFF_FFFF, 32'd70, '0, 5'd0);  // newer view
        send_msg(CMD_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_msg(CMD_PREP_OK, '0, 32'd1, '0, 5'd31);        // seq differs in slot 1
        send_msg(CMD_IN_PREP, '0, 32'd66, 32'd66, 5'd0);    // batch at last_op+1
        op_head = 32'd100;

        // random phases; register extremes among them
        mid_view  = VIEW_W'($urandom_range(1, 1000));
        late_view = VIEW_W'($urandom_range(2000, 100000));
        set_config(1'b1, '0, 4'd3);
        run_phase(80, 1'b0, 1'b0);
        set_config(1'b1, mid_view, 4'd1);
        run_phase(80, 1'b0, 1'b0);
        set_config(1'b0, mid_view, 4'd4);
        run_phase(80, 1'b0, 1'b0);
        set_config(1'b1, mid_view + VIEW_W'(5), 4'd8);
        run_phase(80, 1'b1, 1'b0);
        set_config(1'b1, 31'h7FFF_FFFF, 4'd15);
        run_phase(60, 1'b0, 1'b0);
        set_config(1'b1, 31'h7FFF_FFFF, 4'd0);
        run_phase(60, 1'b0, 1'b0);
        set_config(1'b1, late_view, 4'd2);
        run_phase(80, 1'b0, 1'b1);
        set_config(1'b1, late_view, 4'd5);
        run_phase(80, 1'b0, 1'b0);

        // top of the sequence space last, as last_op never comes back down
        set_config(1'b1, '0, 4'd2);
        send_msg(CMD_OUT_PREP, 31'h7FFF_FFFF, 32'hFFFF_FFFF, '0, 5'd0);
        send_msg(CMD_IN_PREP, '0, 32'hFFFF_FFFE, '0, 5'd0);
        send_msg(CMD_IN_PREP, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
        send_msg(CMD_PREP_OK, 31'h7FFF_FFFF, 32'hFFFF_FFFF, '0, 5'd31);
        send_msg(CMD_PREP_OK, 31'h7FFF_FFFF, 32'hFFFF_FFFF, '0, 5'd7);
        send_msg(CMD_IN_PREP, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);

        drain();
        repeat (10) @(negedge clk);
        $display("tb: %0d messages over nine register settings, %0d verdicts checked",
                 n_sent, n_results);
        $display("tb: %0d delivered, %0d dropped, %0d quorums, %0d mismatches",
                 n_deliver, n_drop, n_quorum, errors);
        if (errors == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[replication_quorum_filter.f]
hdl/rqf_pkg.sv
hdl/rqf_req_if.sv
hdl/rqf_rsp_if.sv
hdl/replication_quorum_filter.sv
dv/rqf_verdict_check.sv
dv/tb.sv
